/* rtl/core/lc3ie_pkg.sv */
// Shared types, codes and helpers for the LC-3 instruction executor.
package lc3ie_pkg;

  // Memory geometry; every address is cut to ADDR_BITS
  localparam int ADDR_BITS = 16;
  localparam int MEM_WORDS = 1 << ADDR_BITS;

  localparam logic [ADDR_BITS-1:0] CTRL_ADDR = ADDR_BITS'(16'hFFFE);
  localparam logic [15:0] START_PC_RST = 16'h3000;
  localparam logic [15:0] CTRL_RST     = 16'h8000;
  localparam logic [15:0] CTRL_HALT    = 16'hFFFF;

  // Condition flags
  localparam logic [2:0] FLAG_N = 3'd4;
  localparam logic [2:0] FLAG_Z = 3'd2;
  localparam logic [2:0] FLAG_P = 3'd1;

  // Trap vectors handled in hardware
  localparam logic [7:0] VEC_GETC  = 8'h20;
  localparam logic [7:0] VEC_OUT   = 8'h21;
  localparam logic [7:0] VEC_PUTS  = 8'h22;
  localparam logic [7:0] VEC_IN    = 8'h23;
  localparam logic [7:0] VEC_PUTSP = 8'h24;
  localparam logic [7:0] VEC_HALT  = 8'h25;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HALT    = 3'd1,
    ST_ZERO    = 3'd2,
    ST_RTI     = 3'd3,
    ST_RSVD    = 3'd4,
    ST_STOPPED = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    OP_BR, OP_ADD, OP_LD, OP_ST, OP_JSR, OP_AND, OP_LDR, OP_STR,
    OP_RTI, OP_NOT, OP_LDI, OP_STI, OP_JMP, OP_RES, OP_LEA, OP_TRAP
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_RDWAIT, S_EXEC, S_MEM1, S_MEM2, S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic mem_wr_item;
    logic mem_rd_item;
    logic rd_take;
    logic fetch;
    logic exec;
    logic mem1;
    logic mem2;
    logic stop5;
    logic publish;
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic stopped;
    logic exec_mem;
    logic mem1_mem2;
    logic res_busy;
  } dp_stat_t;

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    if (v == 16'd0) return FLAG_Z;
    else if (v[15]) return FLAG_N;
    else            return FLAG_P;
  endfunction

endpackage

/* rtl/core/lc3ie_ctrl.sv */
// Sequencer for the LC-3 executor: issues datapath commands per phase.
module lc3ie_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lc3ie_pkg::dp_stat_t stat,
  output lc3ie_pkg::ctl_cmd_t cmd
);
  import lc3ie_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.cmd)
          CMD_WRITE: begin
            cmd.mem_wr_item = 1'b1;
            state_next      = S_DONE;
          end
          CMD_READ: begin
            cmd.mem_rd_item = 1'b1;
            state_next      = S_RDWAIT;
          end
          CMD_STEP: begin
            if (stat.stopped) begin
              cmd.stop5  = 1'b1;
              state_next = S_DONE;
            end else begin
              cmd.fetch  = 1'b1;
              state_next = S_EXEC;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_RDWAIT: begin
        cmd.rd_take = 1'b1;
        state_next  = S_DONE;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.exec_mem ? S_MEM1 : S_DONE;
      end
      S_MEM1: begin
        cmd.mem1   = 1'b1;
        state_next = stat.mem1_mem2 ? S_MEM2 : S_DONE;
      end
      S_MEM2: begin
        cmd.mem2   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // wait for the output slot to free up
        if (!stat.res_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/lc3ie_dp.sv */
// Datapath of the LC-3 executor: memory, register file, PC, flags, result.
module lc3ie_dp (
  input  logic                clk,
  input  logic                rst,
  input  lc3ie_pkg::ctl_cmd_t cmd,
  output lc3ie_pkg::dp_stat_t stat,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic [1:0]          command,
  input  logic [15:0]         address,
  input  logic [15:0]         data,
  input  logic [7:0]          key_char,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [2:0]          status,
  output logic [15:0]         pc_after,
  output logic [15:0]         read_data,
  output logic                out_valid,
  output logic [7:0]          out_char
);
  import lc3ie_pkg::*;

  // Word memory, one port, registered read
  logic [15:0]          mem [MEM_WORDS];
  logic [15:0]          mem_q;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [15:0]          mem_wd;
  logic                 ctrl_init, ctrl_hit_q;
  logic [15:0]          rdata;

  // Architectural state
  logic [15:0] rf [8];
  logic [15:0] pc, pc_next;
  logic [2:0]  flags, flags_next;
  logic        stopped, stopped_next;
  logic [15:0] ir;

  // Captured item
  cmd_t        item_cmd;
  logic [15:0] item_addr, item_data;
  logic [7:0]  item_key;

  // Working result
  status_t     w_status, w_status_next;
  logic [15:0] w_rd, w_rd_next;
  logic        w_ov, w_ov_next;
  logic [7:0]  w_oc, w_oc_next;

  // Register file write port
  logic        rf_we;
  logic [2:0]  rf_wa;
  logic [15:0] rf_wd;

  // Decode
  logic [15:0] cur_ir, pc_inc, off9, off6, off11, src1, src2, alu_b, pc_rel, base_rel;
  opcode_t     opc;
  logic [2:0]  dr, sr1;
  logic [7:0]  vec;

  assign rdata    = ctrl_hit_q ? CTRL_RST : mem_q;
  assign cur_ir   = cmd.exec ? rdata : ir;
  assign opc      = opcode_t'(cur_ir[15:12]);
  assign dr       = cur_ir[11:9];
  assign sr1      = cur_ir[8:6];
  assign vec      = cur_ir[7:0];
  assign off9     = {{7{cur_ir[8]}}, cur_ir[8:0]};
  assign off6     = {{10{cur_ir[5]}}, cur_ir[5:0]};
  assign off11    = {{5{cur_ir[10]}}, cur_ir[10:0]};
  assign src1     = rf[sr1];
  assign src2     = rf[cur_ir[2:0]];
  assign alu_b    = cur_ir[5] ? {{11{cur_ir[4]}}, cur_ir[4:0]} : src2;
  assign pc_inc   = pc + 16'd1;
  assign pc_rel   = pc_inc + off9;
  assign base_rel = src1 + off6;

  // Status to controller
  assign stat.cmd       = item_cmd;
  assign stat.stopped   = stopped;
  assign stat.exec_mem  = (rdata != 16'd0) &&
                          (opc == OP_LD || opc == OP_LDI || opc == OP_LDR ||
                           opc == OP_STI ||
                           (opc == OP_TRAP && vec != VEC_GETC && vec != VEC_OUT &&
                            vec != VEC_PUTS && vec != VEC_IN &&
                            vec != VEC_PUTSP && vec != VEC_HALT));
  assign stat.mem1_mem2 = (opc == OP_LDI);
  assign stat.res_busy  = res_valid && !res_ready;

  // Per-phase next values
  always_comb begin
    mem_we        = 1'b0;
    mem_addr      = pc[ADDR_BITS-1:0];
    mem_wd        = rf[dr];
    rf_we         = 1'b0;
    rf_wa         = dr;
    rf_wd         = 16'd0;
    pc_next       = pc;
    flags_next    = flags;
    stopped_next  = stopped;
    w_status_next = w_status;
    w_rd_next     = w_rd;
    w_ov_next     = w_ov;
    w_oc_next     = w_oc;

    if (cmd.capture) begin
      w_status_next = ST_OK;
      w_rd_next     = 16'd0;
      w_ov_next     = 1'b0;
      w_oc_next     = 8'd0;
    end

    if (cmd.mem_wr_item) begin
      mem_we   = 1'b1;
      mem_addr = item_addr[ADDR_BITS-1:0];
      mem_wd   = item_data;
    end
    if (cmd.mem_rd_item) mem_addr = item_addr[ADDR_BITS-1:0];
    if (cmd.rd_take)     w_rd_next = rdata;
    if (cmd.stop5)       w_status_next = ST_STOPPED;

    // First execute phase: fetched word in rdata
    if (cmd.exec) begin
      pc_next = pc_inc;
      if (rdata == 16'd0) begin
        stopped_next  = 1'b1;
        w_status_next = ST_ZERO;
      end else begin
        case (opc)
          OP_BR:  if ((dr & flags) != 3'd0) pc_next = pc_rel;
          OP_ADD: begin rf_we = 1'b1; rf_wd = src1 + alu_b; end
          OP_AND: begin rf_we = 1'b1; rf_wd = src1 & alu_b; end
          OP_NOT: begin rf_we = 1'b1; rf_wd = ~src1; end
          OP_LEA: begin rf_we = 1'b1; rf_wd = pc_rel; end
          OP_LD, OP_LDI, OP_STI: mem_addr = pc_rel[ADDR_BITS-1:0];
          OP_ST: begin
            mem_we   = 1'b1;
            mem_addr = pc_rel[ADDR_BITS-1:0];
          end
          OP_LDR: mem_addr = base_rel[ADDR_BITS-1:0];
          OP_STR: begin
            mem_we   = 1'b1;
            mem_addr = base_rel[ADDR_BITS-1:0];
          end
          OP_JSR: begin
            rf_we   = 1'b1;
            rf_wa   = 3'd7;
            rf_wd   = pc_inc;
            pc_next = cur_ir[11] ? (pc_inc + off11) : src1;
          end
          OP_JMP: pc_next = src1;
          OP_RTI: begin
            stopped_next  = 1'b1;
            w_status_next = ST_RTI;
          end
          OP_RES: w_status_next = ST_RSVD;
          OP_TRAP: begin
            case (vec)
              VEC_GETC: begin
                rf_we = 1'b1; rf_wa = 3'd0; rf_wd = {8'd0, item_key};
              end
              VEC_OUT: begin
                w_ov_next = 1'b1; w_oc_next = rf[0][7:0];
              end
              VEC_IN: begin
                rf_we = 1'b1; rf_wa = 3'd0; rf_wd = {8'd0, item_key};
                w_ov_next = 1'b1; w_oc_next = item_key;
              end
              VEC_PUTS, VEC_PUTSP: ;
              VEC_HALT: begin
                mem_we        = 1'b1;
                mem_addr      = CTRL_ADDR;
                mem_wd        = CTRL_HALT;
                stopped_next  = 1'b1;
                w_status_next = ST_HALT;
              end
              default: begin
                // vector through memory, link in R7
                rf_we    = 1'b1;
                rf_wa    = 3'd7;
                rf_wd    = pc_inc;
                mem_addr = ADDR_BITS'(vec);
              end
            endcase
          end
          default: ;
        endcase
      end
    end

    // Second phase: first memory word available
    if (cmd.mem1) begin
      case (opc)
        OP_LD, OP_LDR: begin rf_we = 1'b1; rf_wd = rdata; end
        OP_LDI:  mem_addr = rdata[ADDR_BITS-1:0];
        OP_STI: begin
          mem_we   = 1'b1;
          mem_addr = rdata[ADDR_BITS-1:0];
        end
        OP_TRAP: pc_next = rdata;
        default: ;
      endcase
    end

    // Third phase: indirect load data
    if (cmd.mem2) begin
      rf_we = 1'b1;
      rf_wd = rdata;
    end

    // GPR writes other than the JSR/trap link set the flags
    if (rf_we && !((cmd.exec && (opc == OP_JSR || opc == OP_TRAP) && rf_wa == 3'd7)))
      flags_next = flags_of(rf_wd);
  end

  // Memory array
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_q <= mem[mem_addr];
  end

  // Control word reads as its reset value until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_init  <= 1'b1;
      ctrl_hit_q <= 1'b0;
    end else begin
      if (mem_we && mem_addr == CTRL_ADDR) ctrl_init <= 1'b0;
      ctrl_hit_q <= ctrl_init && !mem_we && (mem_addr == CTRL_ADDR);
    end
  end

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) rf[i] <= 16'd0;
    end else if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= START_PC_RST;
      flags     <= FLAG_Z;
      stopped   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) pc <= cfg_wr_data;
      else           pc <= pc_next;
      flags   <= flags_next;
      stopped <= stopped_next;
      if (cmd.publish)    res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  // Item capture, instruction register, working and output result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_cmd  <= cmd_t'(command);
      item_addr <= address;
      item_data <= data;
      item_key  <= key_char;
    end
    if (cmd.exec) ir <= rdata;
    w_status <= w_status_next;
    w_rd     <= w_rd_next;
    w_ov     <= w_ov_next;
    w_oc     <= w_oc_next;
    if (cmd.publish) begin
      status    <= w_status;
      pc_after  <= pc;
      read_data <= w_rd;
      out_valid <= w_ov;
      out_char  <= w_oc;
    end
  end

endmodule

/* rtl/core/lc3_instruction_executor_unit.sv */
// Top level of the LC-3 instruction executor: sequencer plus datapath.
// One item is taken at a time over in_valid/in_ready; its single result is
// held in an output register until res_valid/res_ready completes the transfer,
// and the next item may be accepted meanwhile. States per item: a memory write,
// an unknown command and a step while stopped pass dispatch, then done; a read
// adds a read-wait state; a step fetches, executes, then makes one more memory
// access for LD, LDR, STI and vectored traps, two for LDI, as set by the single
// synchronous memory port. A result still waiting to go holds the done state.
// Memory is undefined until written, except the control word.
module lc3_instruction_executor_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] address,
  input  logic [15:0] data,
  input  logic [7:0]  key_char,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [2:0]  status,
  output logic [15:0] pc_after,
  output logic [15:0] read_data,
  output logic        out_valid,
  output logic [7:0]  out_char
);
  import lc3ie_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  lc3ie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lc3ie_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .command     (command),
    .address     (address),
    .data        (data),
    .key_char    (key_char),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .status      (status),
    .pc_after    (pc_after),
    .read_data   (read_data),
    .out_valid   (out_valid),
    .out_char    (out_char)
  );

`ifndef SYNTHESIS
  // one item in flight: never two input transfers back to back
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  // characters only come with a normal completion
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && status != ST_OK) |-> !out_valid)
    else $error("character output on a stopped or skipped step");

  // read data only on a normal completion
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && read_data != 16'd0) |-> (status == ST_OK))
    else $error("read data with non-ok status");
`endif

endmodule

/* tb/lc3_instruction_executor_unit_test.sv */
// Self-checking testbench for the LC-3 instruction executor: shadow core, scoreboard, stimulus.
module lc3_instruction_executor_unit_test;
  import lc3ie_pkg::*;

  // Expected contents of one result transfer
  typedef struct {
    status_t     status;
    logic [15:0] pc_after;
    logic [15:0] read_data;
    logic        out_valid;
    logic [7:0]  out_char;
  } core_answer_t;

  // Shadow of the core state plus the queue of answers still owed by the block
  class core_shadow;
    logic [15:0]  mem [0:MEM_WORDS-1];
    bit           written [0:MEM_WORDS-1];
    logic [15:0]  regs [0:7];
    logic [15:0]  pc;
    logic [2:0]   flags;
    bit           stopped;
    int           errors;
    core_answer_t owed [$];

    function new();
      for (int i = 0; i < 8; i++) regs[i] = '0;
      mem[CTRL_ADDR] = CTRL_RST;
      written[CTRL_ADDR] = 1;
      pc = START_PC_RST;
      flags = FLAG_Z;
      stopped = 0;
      errors = 0;
    endfunction

    function void set_start(logic [15:0] v);
      pc = v;
    endfunction

    // Memory store, remembering which words hold a value
    function void put(logic [15:0] a, logic [15:0] v);
      mem[a] = v;
      written[a] = 1;
    endfunction

    function void write_reg(logic [2:0] r, logic [15:0] v);
      regs[r] = v;
      if (v == 16'd0) flags = FLAG_Z;
      else if (v[15]) flags = FLAG_N;
      else flags = FLAG_P;
    endfunction

    // One instruction; returns the status and fills the character output
    function status_t exec_step(logic [7:0] key, output logic ov, output logic [7:0] oc);
      logic [15:0] ir, nxt, a, b, off9, base;
      logic [2:0]  dr, sr1;
      opcode_t     op;
      ov = 0;
      oc = '0;
      if (stopped) return ST_STOPPED;
      ir = mem[pc];
      pc = pc + 16'd1;
      nxt = pc;
      if (ir == 16'd0) begin
        stopped = 1;
        return ST_ZERO;
      end
      dr = ir[11:9];
      sr1 = ir[8:6];
      op = opcode_t'(ir[15:12]);
      off9 = nxt + {{7{ir[8]}}, ir[8:0]};
      case (op)
        OP_BR: if ((dr & flags) != 3'd0) pc = off9;
        OP_ADD, OP_AND: begin
          b = ir[5] ? {{11{ir[4]}}, ir[4:0]} : regs[ir[2:0]];
          a = regs[sr1];
          write_reg(dr, (op == OP_ADD) ? a + b : a & b);
        end
        OP_LD:  write_reg(dr, mem[off9]);
        OP_ST:  put(off9, regs[dr]);
        OP_JSR: begin
          // base taken before the link so that JSRR R7 jumps to the old R7
          base = regs[sr1];
          regs[7] = nxt;
          pc = ir[11] ? nxt + {{5{ir[10]}}, ir[10:0]} : base;
        end
        OP_LDR: write_reg(dr, mem[regs[sr1] + {{10{ir[5]}}, ir[5:0]}]);
        OP_STR: put(regs[sr1] + {{10{ir[5]}}, ir[5:0]}, regs[dr]);
        OP_RTI: begin
          stopped = 1;
          return ST_RTI;
        end
        OP_NOT: write_reg(dr, ~regs[sr1]);
        OP_LDI: write_reg(dr, mem[mem[off9]]);
        OP_STI: put(mem[off9], regs[dr]);
        OP_JMP: pc = regs[sr1];
        OP_RES: return ST_RSVD;
        OP_LEA: write_reg(dr, off9);
        default: begin
          case (ir[7:0])
            VEC_GETC: write_reg(3'd0, {8'h00, key});
            VEC_OUT: begin
              ov = 1;
              oc = regs[0][7:0];
            end
            VEC_IN: begin
              ov = 1;
              oc = key;
              write_reg(3'd0, {8'h00, key});
            end
            VEC_PUTS, VEC_PUTSP: ;
            VEC_HALT: begin
              put(CTRL_ADDR, CTRL_HALT);
              stopped = 1;
              return ST_HALT;
            end
            default: begin
              regs[7] = nxt;
              pc = mem[{8'h00, ir[7:0]}];
            end
          endcase
        end
      endcase
      return ST_OK;
    endfunction

    // Accepted input transfer: advance the shadow and queue the answer
    function void note_item(cmd_t cmd, logic [15:0] addr, logic [15:0] wdata,
                            logic [7:0] key);
      core_answer_t ans;
      ans.status = ST_OK;
      ans.read_data = '0;
      ans.out_valid = 0;
      ans.out_char = '0;
      case (cmd)
        CMD_WRITE: put(addr, wdata);
        CMD_READ:  ans.read_data = mem[addr];
        CMD_STEP:  ans.status = exec_step(key, ans.out_valid, ans.out_char);
        default: ;
      endcase
      ans.pc_after = pc;
      owed.push_back(ans);
    endfunction

    // Accepted result transfer: compare with the oldest answer owed
    function void check_result(logic [2:0] st, logic [15:0] pca, logic [15:0] rd,
                               logic ov, logic [7:0] oc);
      core_answer_t e;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed: status %0d pc %h", $time, st, pca);
        return;
      end
      e = owed.pop_front();
      if (st !== e.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
      end
      if (pca !== e.pc_after) begin
        errors++;
        $display("%0t: pc_after expected %h actual %h", $time, e.pc_after, pca);
      end
      if (rd !== e.read_data) begin
        errors++;
        $display("%0t: read_data expected %h actual %h", $time, e.read_data, rd);
      end
      if (ov !== e.out_valid) begin
        errors++;
        $display("%0t: out_valid expected %b actual %b", $time, e.out_valid, ov);
      end
      if (oc !== e.out_char) begin
        errors++;
        $display("%0t: out_char expected %h actual %h", $time, e.out_char, oc);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [15:0] address;
  logic [15:0] data;
  logic [7:0]  key_char;
  logic        res_valid;
  logic        res_ready;
  logic [2:0]  status;
  logic [15:0] pc_after;
  logic [15:0] read_data;
  logic        out_valid;
  logic [7:0]  out_char;

  core_shadow core;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         sent;

  lc3_instruction_executor_unit dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .address(address), .data(data), .key_char(key_char),
    .res_valid(res_valid), .res_ready(res_ready),
    .status(status), .pc_after(pc_after), .read_data(read_data),
    .out_valid(out_valid), .out_char(out_char)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stalls, check every result transfer
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready)
      core.check_result(status, pc_after, read_data, out_valid, out_char);
    res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Keep clear of words that would stop the core for good
  function automatic logic [15:0] runnable(logic [15:0] w);
    if (w == 16'd0 || w[15:12] == OP_RTI ||
        (w[15:12] == OP_TRAP && w[7:0] == VEC_HALT))
      return w ^ 16'h4000;
    return w;
  endfunction

  function automatic bit is_stopping(logic [15:0] w);
    return runnable(w) != w;
  endfunction

  // One input transfer; called just after a rising edge
  task automatic send(cmd_t cmd, logic [15:0] addr, logic [15:0] wdata, logic [7:0] key);
    in_valid <= 1;
    command  <= cmd;
    address  <= addr;
    data     <= wdata;
    key_char <= key;
    do @(posedge clk); while (!in_ready);
    core.note_item(cmd, addr, wdata, key);
    sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (core.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_start_pc(logic [15:0] v);
    drain();
    cfg_wr_en   <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 0;
    core.set_start(v);
    @(posedge clk);
  endtask

  // Give a word a value before anything reads it
  task automatic ensure(logic [15:0] a);
    if (!core.written[a])
      send(CMD_WRITE, a, runnable(16'($urandom)), 8'h00);
  endtask

  // Write every word that the instruction at pc will read
  task automatic prep_operands();
    logic [15:0] w, ea;
    w  = core.mem[core.pc];
    ea = core.pc + 16'd1 + {{7{w[8]}}, w[8:0]};
    case (w[15:12])
      OP_LD, OP_STI: ensure(ea);
      OP_LDI: begin
        ensure(ea);
        ensure(core.mem[ea]);
      end
      OP_LDR: ensure(core.regs[w[8:6]] + {{10{w[5]}}, w[5:0]});
      OP_TRAP: if (w[7:0] < VEC_GETC || w[7:0] > VEC_HALT) ensure({8'h00, w[7:0]});
      default: ;
    endcase
  endtask

  // Place an instruction at the current pc and step it
  task automatic run_word(logic [15:0] w, logic [7:0] key);
    send(CMD_WRITE, core.pc, w, 8'h00);
    prep_operands();
    send(CMD_STEP, 16'($urandom), 16'($urandom), key);
  endtask

  // Step, first giving pc a runnable word if it has none
  task automatic safe_step();
    if (!core.written[core.pc] || is_stopping(core.mem[core.pc]))
      send(CMD_WRITE, core.pc, runnable(16'($urandom)), 8'h00);
    prep_operands();
    send(CMD_STEP, 16'($urandom), 16'($urandom), 8'($urandom_range(255)));
  endtask

  // Random traffic until n more input transfers have gone
  task automatic random_items(int n);
    int          pick, stop_at;
    bit          held;
    logic [15:0] addr;
    stop_at = sent + n;
    held = 0;
    while (sent < stop_at) begin
      pick = int'($urandom_range(99));
      if (pick < 50) begin
        run_word(runnable(16'($urandom)), 8'($urandom_range(255)));
      end else if (pick < 75) begin
        safe_step();
      end else if (pick < 85) begin
        send(CMD_WRITE, 16'($urandom), runnable(16'($urandom)), 8'($urandom_range(255)));
      end else if (pick < 95) begin
        addr = 16'($urandom);
        ensure(addr);
        send(CMD_READ, addr, 16'($urandom), 8'($urandom_range(255)));
      end else begin
        send(CMD_NONE, 16'($urandom), 16'($urandom), 8'($urandom_range(255)));
      end
      // hold off once until the block has answered everything
      if (!held && send_idle_pct != 0 && sent >= stop_at - n / 2) begin
        drain();
        held = 1;
      end
    end
  endtask

  initial begin
    logic [15:0] stop_word;
    core = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sent           = 0;
    rst         <= 1;
    cfg_wr_en   <= 0;
    cfg_wr_data <= '0;
    in_valid    <= 0;
    command     <= CMD_NONE;
    address     <= '0;
    data        <= '0;
    key_char    <= '0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: every opcode but RTI, operand extremes, handled and vectored traps
    run_word(16'h126F, 8'h00);  // ADD R1,R1,#15
    run_word(16'h1470, 8'h00);  // ADD R2,R1,#-16
    run_word(16'h1642, 8'h00);  // ADD R3,R1,R2
    run_word(16'h58FF, 8'h00);  // AND R4,R3,#-1
    run_word(16'h5A42, 8'h00);  // AND R5,R1,R2
    run_word(16'h9CBF, 8'h00);  // NOT R6,R2
    run_word(16'h0EFF, 8'h00);  // BRnzp +255
    run_word(16'h0F00, 8'h00);  // BRnzp -256
    run_word(16'h2100, 8'h00);  // LD R0,-256
    run_word(16'hA2FF, 8'h00);  // LDI R1,+255
    run_word(16'h65A0, 8'h00);  // LDR R2,R6,#-32
    run_word(16'h665F, 8'h00);  // LDR R3,R1,#31
    run_word(16'hEEFF, 8'h00);  // LEA R7,+255
    run_word(16'h37FF, 8'h00);  // ST R3,-1
    run_word(16'hB801, 8'h00);  // STI R4,+1
    run_word(16'h7A3F, 8'h00);  // STR R5,R0,#-1
    run_word(16'h4BFF, 8'h00);  // JSR +1023
    run_word(16'h4C00, 8'h00);  // JSR -1024
    run_word(16'h41C0, 8'h00);  // JSRR R7
    run_word(16'hC1C0, 8'h00);  // JMP R7
    run_word(16'hD123, 8'h00);  // reserved opcode
    run_word(16'hF020, 8'hFF);  // GETC
    run_word(16'hF021, 8'h00);  // OUT
    run_word(16'hF022, 8'h00);  // PUTS
    run_word(16'hF023, 8'h00);  // IN
    run_word(16'hF024, 8'h00);  // PUTSP
    run_word(16'hF0FF, 8'h00);  // vectored trap
    run_word(16'hF000, 8'h00);  // vectored trap, vector 0
    send(CMD_WRITE, 16'hFFFF, 16'hFFFF, 8'hFF);
    send(CMD_READ, 16'hFFFF, 16'h0000, 8'h00);
    ensure(16'h0000);
    send(CMD_READ, 16'h0000, 16'hFFFF, 8'h00);
    send(CMD_NONE, 16'hFFFF, 16'hFFFF, 8'hFF);

    // Random phases under different idling, start pc changed between them
    set_start_pc(16'h0000);
    random_items(400);
    set_start_pc(16'hFFFF);
    send_idle_pct = 86;
    random_items(400);
    set_start_pc(16'($urandom));
    send_idle_pct  = 0;
    recv_stall_pct = 86;
    random_items(400);
    set_start_pc(START_PC_RST);
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    random_items(400);

    // Stop the core once, then exercise commands while stopped
    case ($urandom_range(2))
      0:       stop_word = 16'h0000;
      1:       stop_word = {4'(OP_RTI), 12'($urandom)};
      default: stop_word = {8'hF0, VEC_HALT};
    endcase
    run_word(stop_word, 8'h00);
    send(CMD_STEP, 16'h0000, 16'h0000, 8'h00);
    send(CMD_READ, 16'(CTRL_ADDR), 16'h0000, 8'h00);
    send(CMD_WRITE, 16'h1234, 16'h0000, 8'h00);
    send(CMD_READ, 16'h1234, 16'h0000, 8'h00);
    send(CMD_NONE, 16'h0000, 16'h0000, 8'h00);
    send(CMD_STEP, 16'hFFFF, 16'hFFFF, 8'hFF);
    drain();

    if (core.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
